// File: rtl/core/assert_macros.svh
// Assertion macros for the RTL files that check their own behaviour.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/core/yq2rgb_pkg.sv
package yq2rgb_pkg;

    // Width of every intermediate sum; all of them fit in 21 signed bits.
    localparam int SUM_W = 21;

    typedef enum logic
    {
        MODE_SHIFT5 = 1'b0,
        MODE_BT601  = 1'b1
    } mode_t;

    // BT.601 studio range, Q10.
    localparam logic signed [SUM_W-1:0] BT_Y    = 21'sd1192;
    localparam logic signed [SUM_W-1:0] BT_RND  = 21'sd512;
    localparam logic signed [SUM_W-1:0] BT_RV   = 21'sd1634;
    localparam logic signed [SUM_W-1:0] BT_GV   = 21'sd833;
    localparam logic signed [SUM_W-1:0] BT_GU   = 21'sd400;
    localparam logic signed [SUM_W-1:0] BT_BU   = 21'sd2066;
    localparam logic [7:0]              BT_YMIN = 8'd16;
    localparam int                      BT_SHIFT = 10;

    // Shift-by-5 approximation.
    localparam logic signed [SUM_W-1:0] AP_RV   = 21'sd45;
    localparam logic signed [SUM_W-1:0] AP_GU   = 21'sd11;
    localparam logic signed [SUM_W-1:0] AP_GV   = 21'sd23;
    localparam logic signed [SUM_W-1:0] AP_BU   = 21'sd57;
    localparam int                      AP_SHIFT = 5;

    typedef struct packed
    {
        logic [7:0] luma_top_left;
        logic [7:0] luma_top_right;
        logic [7:0] luma_bottom_left;
        logic [7:0] luma_bottom_right;
        logic [7:0] chroma_v;
        logic [7:0] chroma_u;
    } quad_t;

    typedef struct packed
    {
        logic [7:0] red_top_left;
        logic [7:0] green_top_left;
        logic [7:0] blue_top_left;
        logic [7:0] red_top_right;
        logic [7:0] green_top_right;
        logic [7:0] blue_top_right;
        logic [7:0] red_bottom_left;
        logic [7:0] green_bottom_left;
        logic [7:0] blue_bottom_left;
        logic [7:0] red_bottom_right;
        logic [7:0] green_bottom_right;
        logic [7:0] blue_bottom_right;
    } rgb_t;

    // Control from the top level to the first pipeline stage.
    typedef struct packed
    {
        logic  load;
        mode_t mode;
    } stage_ctrl_t;

    // Registered chroma contributions shared by all four lanes.
    typedef struct packed
    {
        mode_t                   mode;
        logic signed [SUM_W-1:0] red;
        logic signed [SUM_W-1:0] green;
        logic signed [SUM_W-1:0] blue;
    } chroma_terms_t;

    typedef struct packed
    {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } lane_rgb_t;

endpackage

// File: rtl/core/yq2rgb_chroma.sv
module yq2rgb_chroma
(
    input  logic                      clk,
    input  yq2rgb_pkg::stage_ctrl_t   ctrl,
    input  logic [7:0]                chroma_v,
    input  logic [7:0]                chroma_u,
    output yq2rgb_pkg::chroma_terms_t terms
);

    // Offset-binary chroma: subtracting 128 flips the top bit.
    logic signed [7:0]                    v_c;
    logic signed [7:0]                    u_c;
    logic signed [yq2rgb_pkg::SUM_W-1:0]  v_ext;
    logic signed [yq2rgb_pkg::SUM_W-1:0]  u_ext;
    yq2rgb_pkg::chroma_terms_t            terms_next;
    yq2rgb_pkg::chroma_terms_t            terms_reg;

    assign v_c   = $signed({~chroma_v[7], chroma_v[6:0]});
    assign u_c   = $signed({~chroma_u[7], chroma_u[6:0]});
    assign v_ext = yq2rgb_pkg::SUM_W'(v_c);
    assign u_ext = yq2rgb_pkg::SUM_W'(u_c);

    always_comb
    begin
        terms_next.mode = ctrl.mode;
        case (ctrl.mode)
            yq2rgb_pkg::MODE_BT601:
            begin
                terms_next.red   = v_ext * yq2rgb_pkg::BT_RV;
                terms_next.green = -(v_ext * yq2rgb_pkg::BT_GV)
                                   - (u_ext * yq2rgb_pkg::BT_GU);
                terms_next.blue  = u_ext * yq2rgb_pkg::BT_BU;
            end
            default:
            begin
                // Each product is floored on its own before the sums.
                terms_next.red   = (v_ext * yq2rgb_pkg::AP_RV) >>> yq2rgb_pkg::AP_SHIFT;
                terms_next.green = -(((u_ext * yq2rgb_pkg::AP_GU) >>> yq2rgb_pkg::AP_SHIFT)
                                   + ((v_ext * yq2rgb_pkg::AP_GV) >>> yq2rgb_pkg::AP_SHIFT));
                terms_next.blue  = (u_ext * yq2rgb_pkg::AP_BU) >>> yq2rgb_pkg::AP_SHIFT;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            terms_reg <= terms_next;
        end
    end

    assign terms = terms_reg;

endmodule

// File: rtl/core/yq2rgb_lane.sv
module yq2rgb_lane
(
    input  logic                      clk,
    input  yq2rgb_pkg::stage_ctrl_t   ctrl,
    input  logic [7:0]                luma,
    input  yq2rgb_pkg::chroma_terms_t terms,
    output yq2rgb_pkg::lane_rgb_t     rgb
);

    logic [7:0]                           luma_clamped;
    logic signed [yq2rgb_pkg::SUM_W-1:0]  luma_ext;
    logic signed [yq2rgb_pkg::SUM_W-1:0]  luma_term_next;
    logic signed [yq2rgb_pkg::SUM_W-1:0]  luma_term_reg;
    logic signed [yq2rgb_pkg::SUM_W-1:0]  sum_r;
    logic signed [yq2rgb_pkg::SUM_W-1:0]  sum_g;
    logic signed [yq2rgb_pkg::SUM_W-1:0]  sum_b;

    function automatic logic [7:0] sat8(input logic signed [yq2rgb_pkg::SUM_W-1:0] x);
        logic [7:0] res;
        if (x < 0)
            res = 8'd0;
        else if (x > 255)
            res = 8'd255;
        else
            res = x[7:0];
        return res;
    endfunction

    function automatic logic signed [yq2rgb_pkg::SUM_W-1:0] scale(
        input yq2rgb_pkg::mode_t           mode,
        input logic signed [yq2rgb_pkg::SUM_W-1:0] x);
        logic signed [yq2rgb_pkg::SUM_W-1:0] res;
        case (mode)
            yq2rgb_pkg::MODE_BT601: res = x >>> yq2rgb_pkg::BT_SHIFT;
            default:                res = x;
        endcase
        return res;
    endfunction

    // First stage: the luma contribution of this lane.
    assign luma_clamped = (luma < yq2rgb_pkg::BT_YMIN) ? yq2rgb_pkg::BT_YMIN : luma;
    assign luma_ext     = $signed(yq2rgb_pkg::SUM_W'(luma_clamped - yq2rgb_pkg::BT_YMIN));

    always_comb
    begin
        case (ctrl.mode)
            yq2rgb_pkg::MODE_BT601:
                luma_term_next = luma_ext * yq2rgb_pkg::BT_Y + yq2rgb_pkg::BT_RND;
            default:
                luma_term_next = $signed(yq2rgb_pkg::SUM_W'(luma));
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            luma_term_reg <= luma_term_next;
        end
    end

    // Second stage: add the shared chroma terms, scale in BT.601 mode and saturate.
    assign sum_r = luma_term_reg + terms.red;
    assign sum_g = luma_term_reg + terms.green;
    assign sum_b = luma_term_reg + terms.blue;

    assign rgb.red   = sat8(scale(terms.mode, sum_r));
    assign rgb.green = sat8(scale(terms.mode, sum_g));
    assign rgb.blue  = sat8(scale(terms.mode, sum_b));

endmodule

// File: rtl/core/yuv420_quad_to_rgb.sv
// NV21 2x2 quad to RGB converter. One transfer on the quad channel carries
// the four Y samples of a 2x2 luma block and the V and U bytes they share;
// one transfer on the rgb channel returns the four RGB pixels of that block
// in the same order, each channel saturated to 0..255. With conversion mode
// 1 (the reset value) the BT.601 studio-range equations are used in Q10 fixed
// point with luma raised to at least 16; with mode 0 a cheap shift-by-5
// integer approximation is used. A new quad is taken every clock cycle
// unless both stages hold data and the rgb channel is not ready; its result
// passes from the first-stage registers into the output register before it
// is offered. One stage forms the per-lane luma and shared chroma products,
// the second adds, scales and saturates into the output register. Write the
// mode only while no quad is in flight.
`include "assert_macros.svh"

module yuv420_quad_to_rgb
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              mode_we,
    input  logic              mode_wdata,

    input  logic              quad_valid,
    output logic              quad_ready,
    input  yq2rgb_pkg::quad_t quad,

    output logic              rgb_valid,
    input  logic              rgb_ready,
    output yq2rgb_pkg::rgb_t  rgb
);

    yq2rgb_pkg::mode_t          mode_reg;
    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    logic                       rgb_valid_reg;
    logic                       rgb_valid_next;
    yq2rgb_pkg::rgb_t           rgb_reg;
    logic                       in_xfer;
    logic                       out_load;
    yq2rgb_pkg::stage_ctrl_t    s1_ctrl;
    yq2rgb_pkg::chroma_terms_t  terms;
    yq2rgb_pkg::lane_rgb_t      lane_tl;
    yq2rgb_pkg::lane_rgb_t      lane_tr;
    yq2rgb_pkg::lane_rgb_t      lane_bl;
    yq2rgb_pkg::lane_rgb_t      lane_br;

    // Conversion mode register; only bit 0 of the written value exists.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= yq2rgb_pkg::MODE_BT601;
        end
        else if (mode_we)
        begin
            mode_reg <= yq2rgb_pkg::mode_t'(mode_wdata);
        end
    end

    // The second stage moves into the output register whenever that register
    // is empty or its content is being transferred in this cycle. The first
    // stage can take a new quad whenever it is empty or is moving on, so a
    // full output register that is being drained never stalls the input.
    assign out_load   = s1_valid_reg && (!rgb_valid_reg || rgb_ready);
    assign quad_ready = !s1_valid_reg || out_load;
    assign in_xfer    = quad_valid && quad_ready;

    assign s1_ctrl.load = in_xfer;
    assign s1_ctrl.mode = mode_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
            s1_valid_next = 1'b1;
        else if (out_load)
            s1_valid_next = 1'b0;

        rgb_valid_next = rgb_valid_reg;
        if (out_load)
            rgb_valid_next = 1'b1;
        else if (rgb_ready)
            rgb_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rgb_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rgb_valid_reg <= rgb_valid_next;
        end
    end

    // Chroma products are formed once per quad and shared by the four lanes.
    yq2rgb_chroma u_chroma
    (
        .clk      (clk),
        .ctrl     (s1_ctrl),
        .chroma_v (quad.chroma_v),
        .chroma_u (quad.chroma_u),
        .terms    (terms)
    );

    yq2rgb_lane u_lane_tl
    (
        .clk   (clk),
        .ctrl  (s1_ctrl),
        .luma  (quad.luma_top_left),
        .terms (terms),
        .rgb   (lane_tl)
    );

    yq2rgb_lane u_lane_tr
    (
        .clk   (clk),
        .ctrl  (s1_ctrl),
        .luma  (quad.luma_top_right),
        .terms (terms),
        .rgb   (lane_tr)
    );

    yq2rgb_lane u_lane_bl
    (
        .clk   (clk),
        .ctrl  (s1_ctrl),
        .luma  (quad.luma_bottom_left),
        .terms (terms),
        .rgb   (lane_bl)
    );

    yq2rgb_lane u_lane_br
    (
        .clk   (clk),
        .ctrl  (s1_ctrl),
        .luma  (quad.luma_bottom_right),
        .terms (terms),
        .rgb   (lane_br)
    );

    // Output register: gathers the four lane results into one result item.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            rgb_reg.red_top_left       <= lane_tl.red;
            rgb_reg.green_top_left     <= lane_tl.green;
            rgb_reg.blue_top_left      <= lane_tl.blue;
            rgb_reg.red_top_right      <= lane_tr.red;
            rgb_reg.green_top_right    <= lane_tr.green;
            rgb_reg.blue_top_right     <= lane_tr.blue;
            rgb_reg.red_bottom_left    <= lane_bl.red;
            rgb_reg.green_bottom_left  <= lane_bl.green;
            rgb_reg.blue_bottom_left   <= lane_bl.blue;
            rgb_reg.red_bottom_right   <= lane_br.red;
            rgb_reg.green_bottom_right <= lane_br.green;
            rgb_reg.blue_bottom_right  <= lane_br.blue;
        end
    end

    assign rgb_valid = rgb_valid_reg;
    assign rgb       = rgb_reg;

    // The input stalls only when both stages hold data and the output is held.
    `ASSERT_SAME(a_stall_cause, clk, rst_n, !quad_ready,
                 s1_valid_reg && rgb_valid_reg && !rgb_ready)
    // An accepted quad always occupies the first stage in the next cycle.
    `ASSERT_NEXT(a_s1_fill, clk, rst_n, in_xfer, s1_valid_reg)
    // A first-stage item that may move on always reaches the output register.
    `ASSERT_NEXT(a_out_fill, clk, rst_n, out_load, rgb_valid_reg)

endmodule

// File: bench/tb_yuv420_quad_to_rgb.sv
`timescale 1ns / 1ps

module tb_yuv420_quad_to_rgb;

    // The block is two stages deep. These pauses are waited out after the last
    // owed result has been returned.
    localparam int PIPE_SETTLE  = 4;
    localparam int END_SETTLE   = 6;
    // The limit lies beyond any correct run, so it only trips when the
    // handshake has locked up.
    localparam int CYCLE_LIMIT  = 200000;
    // The receiver's long hold-off. The pipeline fills long before it ends.
    localparam int LONG_HOLD    = 200;
    localparam int N_CASES      = 18;

    localparam yq2rgb_pkg::mode_t M_BT601  = yq2rgb_pkg::MODE_BT601;
    localparam yq2rgb_pkg::mode_t M_SHIFT5 = yq2rgb_pkg::MODE_SHIFT5;

    typedef struct
    {
        yq2rgb_pkg::mode_t mode;
        yq2rgb_pkg::quad_t q;
        bit                typed;
        yq2rgb_pkg::rgb_t  want;
    } quad_case_t;

    logic              clk;
    logic              rst_n      = 1'b0;
    logic              mode_we    = 1'b0;
    logic              mode_wdata = 1'b0;
    logic              quad_valid = 1'b0;
    logic              quad_ready;
    yq2rgb_pkg::quad_t quad       = '0;
    logic              rgb_valid;
    logic              rgb_ready  = 1'b0;
    yq2rgb_pkg::rgb_t  rgb;

    // The mode that the block holds, as the bench sees it. It changes only
    // while nothing is in flight.
    yq2rgb_pkg::mode_t model_mode = M_BT601;

    // Pixels still owed by the block, oldest first.
    yq2rgb_pkg::rgb_t  pending_rgb [$];

    // Directed rows with a result known by inspection carry it here, so the
    // monitor pushes it instead of the predicted value.
    bit                quad_typed = 1'b0;
    yq2rgb_pkg::rgb_t  quad_typed_rgb = '0;

    bit    sender_idles   = 1'b0;
    bit    receiver_idles = 1'b0;
    bit    hold_request   = 1'b0;

    int    cycle_count    = 0;
    int    quads_sent     = 0;
    int    quads_shift5   = 0;
    int    quads_bt601    = 0;
    int    rgb_checked    = 0;
    int    stall_cycles   = 0;
    int    mismatch_count = 0;

    string rgb_field_name [12] = '{
        "red_top_left",     "green_top_left",     "blue_top_left",
        "red_top_right",    "green_top_right",    "blue_top_right",
        "red_bottom_left",  "green_bottom_left",  "blue_bottom_left",
        "red_bottom_right", "green_bottom_right", "blue_bottom_right"
    };

    // Directed stimulus: black and white in both modes, luma either side of
    // the studio-range floor of 16, chroma at both rails and just either side
    // of its midpoint (where the shift-by-5 terms round towards minus
    // infinity), and results that saturate at both ends.
    quad_case_t quad_cases [N_CASES] = '{
        '{M_BT601,  {8'd0,   8'd0,   8'd0,   8'd0,   8'd128, 8'd128}, 1'b1, {12{8'h00}}},
        '{M_BT601,  {8'd255, 8'd255, 8'd255, 8'd255, 8'd128, 8'd128}, 1'b1, {12{8'hFF}}},
        '{M_BT601,  {8'd15,  8'd16,  8'd17,  8'd235, 8'd128, 8'd128}, 1'b0, '0},
        '{M_BT601,  {8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}, 1'b0, '0},
        '{M_BT601,  {8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},   1'b0, '0},
        '{M_BT601,  {8'd0,   8'd85,  8'd170, 8'd255, 8'd0,   8'd255}, 1'b0, '0},
        '{M_BT601,  {8'd128, 8'd64,  8'd192, 8'd32,  8'd255, 8'd0},   1'b0, '0},
        '{M_BT601,  {8'd100, 8'd200, 8'd50,  8'd16,  8'd127, 8'd129}, 1'b0, '0},
        '{M_SHIFT5, {8'd0,   8'd0,   8'd0,   8'd0,   8'd128, 8'd128}, 1'b1, {12{8'h00}}},
        '{M_SHIFT5, {8'd255, 8'd255, 8'd255, 8'd255, 8'd128, 8'd128}, 1'b1, {12{8'hFF}}},
        '{M_SHIFT5, {8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},   1'b0, '0},
        '{M_SHIFT5, {8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}, 1'b0, '0},
        '{M_SHIFT5, {8'd10,  8'd20,  8'd30,  8'd40,  8'd127, 8'd127}, 1'b0, '0},
        '{M_SHIFT5, {8'd250, 8'd251, 8'd252, 8'd253, 8'd129, 8'd129}, 1'b0, '0},
        '{M_SHIFT5, {8'd0,   8'd255, 8'd0,   8'd255, 8'd0,   8'd255}, 1'b0, '0},
        '{M_SHIFT5, {8'd255, 8'd0,   8'd255, 8'd0,   8'd255, 8'd0},   1'b0, '0},
        '{M_BT601,  {8'd16,  8'd16,  8'd16,  8'd16,  8'd128, 8'd128}, 1'b1, {12{8'h00}}},
        '{M_BT601,  {8'd235, 8'd240, 8'd250, 8'd14,  8'd128, 8'd128}, 1'b0, '0}
    };

    yuv420_quad_to_rgb DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode_we    (mode_we),
        .mode_wdata (mode_wdata),
        .quad_valid (quad_valid),
        .quad_ready (quad_ready),
        .quad       (quad),
        .rgb_valid  (rgb_valid),
        .rgb_ready  (rgb_ready),
        .rgb        (rgb)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Colour conversion predictor
    // ------------------------------------------------------------------

    function automatic logic [7:0] saturate(input int x);
        if (x < 0)
            return 8'd0;
        if (x > 255)
            return 8'd255;
        return x[7:0];
    endfunction

    // One luma sample with the shared chroma offsets. On a signed int the
    // >>> operator floors, which is the rounding the block is specified with.
    function automatic yq2rgb_pkg::lane_rgb_t convert_sample(input int y, input int u,
                                                             input int v,
                                                             input yq2rgb_pkg::mode_t m);
        yq2rgb_pkg::lane_rgb_t lane;
        int                    yy;
        int                    base;
        if (m == M_BT601)
        begin
            // Studio range: luma below black is taken as black.
            yy = (y < 16) ? 0 : y - 16;
            base = 1192 * yy + 512;
            lane.red   = saturate((base + 1634 * v) >>> 10);
            lane.green = saturate((base - 833 * v - 400 * u) >>> 10);
            lane.blue  = saturate((base + 2066 * u) >>> 10);
        end
        else
        begin
            lane.red   = saturate(y + ((45 * v) >>> 5));
            lane.green = saturate(y - (((11 * u) >>> 5) + ((23 * v) >>> 5)));
            lane.blue  = saturate(y + ((57 * u) >>> 5));
        end
        return lane;
    endfunction

    function automatic yq2rgb_pkg::rgb_t convert_quad(input yq2rgb_pkg::quad_t q,
                                                      input yq2rgb_pkg::mode_t m);
        int                    v;
        int                    u;
        yq2rgb_pkg::lane_rgb_t tl;
        yq2rgb_pkg::lane_rgb_t tr;
        yq2rgb_pkg::lane_rgb_t bl;
        yq2rgb_pkg::lane_rgb_t br;
        v  = int'(q.chroma_v) - 128;
        u  = int'(q.chroma_u) - 128;
        tl = convert_sample(int'(q.luma_top_left), u, v, m);
        tr = convert_sample(int'(q.luma_top_right), u, v, m);
        bl = convert_sample(int'(q.luma_bottom_left), u, v, m);
        br = convert_sample(int'(q.luma_bottom_right), u, v, m);
        return {tl, tr, bl, br};
    endfunction

    // ------------------------------------------------------------------
    // Monitors, all sampling at the rising edge
    // ------------------------------------------------------------------

    // Every accepted quad owes exactly one set of four pixels.
    always @(posedge clk)
    begin
        if (rst_n && quad_valid)
        begin
            if (quad_ready)
            begin
                pending_rgb.push_back(quad_typed ? quad_typed_rgb
                                                 : convert_quad(quad, model_mode));
                quads_sent++;
                if (model_mode == M_BT601)
                    quads_bt601++;
                else
                    quads_shift5++;
            end
            else
            begin
                stall_cycles++;
            end
        end
    end

    // Each returned transfer is compared, channel by channel, with the oldest
    // expectation. Mismatches are counted and the run carries on.
    always @(posedge clk)
    begin
        yq2rgb_pkg::rgb_t want;
        logic [7:0]       want_b;
        logic [7:0]       got_b;
        if (rst_n && rgb_valid && rgb_ready)
        begin
            if (pending_rgb.size() == 0)
            begin
                $display("%0t ns: rgb transfer with none expected: expected nothing, actual %h",
                         $time, rgb);
                mismatch_count++;
            end
            else
            begin
                want = pending_rgb.pop_front();
                rgb_checked++;
                for (int k = 0; k < 12; k++)
                begin
                    want_b = want[95 - 8 * k -: 8];
                    got_b  = rgb[95 - 8 * k -: 8];
                    if (got_b !== want_b)
                    begin
                        $display("%0t ns: %s mismatch: expected %0d, actual %0d",
                                 $time, rgb_field_name[k], want_b, got_b);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending_rgb.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure in bursts, plus one long hold-off on
    // request so that the pipeline fills and the quad channel stalls.
    // ------------------------------------------------------------------

    initial
    begin
        int gap;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                rgb_ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_request = 1'b0;
                rgb_ready = 1'b1;
            end
            else if (receiver_idles && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 14);
                rgb_ready = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            else
            begin
                rgb_ready = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offers one quad from a falling edge and returns at the rising edge on
    // which it transfers. Valid stays up between back-to-back quads.
    task automatic send_quad(input yq2rgb_pkg::quad_t q, input bit typed,
                             input yq2rgb_pkg::rgb_t want);
        int gap;
        @(negedge clk);
        if (sender_idles && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 14);
            quad_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        quad           = q;
        quad_typed     = typed;
        quad_typed_rgb = want;
        quad_valid     = 1'b1;
        do
            @(posedge clk);
        while (!quad_ready);
    endtask

    // Lowers valid, waits for every owed result and for the pipeline to
    // settle, and only then writes the mode register.
    task automatic set_mode(input yq2rgb_pkg::mode_t m);
        @(negedge clk);
        quad_valid = 1'b0;
        quad_typed = 1'b0;
        while (pending_rgb.size() != 0)
            @(posedge clk);
        repeat (PIPE_SETTLE) @(negedge clk);
        mode_wdata = m;
        mode_we    = 1'b1;
        @(negedge clk);
        mode_we    = 1'b0;
        model_mode = m;
    endtask

    // Luma is weighted towards the black floor, the top of studio range and
    // the rails; chroma towards the rails and its midpoint.
    function automatic logic [7:0] pick_luma();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'($urandom_range(14, 17));
            3:       return 8'($urandom_range(233, 241));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_chroma();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'($urandom_range(126, 130));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic run_random(input int count, input yq2rgb_pkg::mode_t m, input bit idles,
                              input bit long_hold);
        yq2rgb_pkg::quad_t q;
        set_mode(m);
        sender_idles   = idles;
        receiver_idles = idles;
        if (long_hold)
            hold_request = 1'b1;
        repeat (count)
        begin
            q.luma_top_left     = pick_luma();
            q.luma_top_right    = pick_luma();
            q.luma_bottom_left  = pick_luma();
            q.luma_bottom_right = pick_luma();
            q.chroma_v          = pick_chroma();
            q.chroma_u          = pick_chroma();
            send_quad(q, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // Directed rows, starting in the reset mode. The register is written
        // whenever a row asks for the other mode.
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        for (int i = 0; i < N_CASES; i++)
        begin
            if (quad_cases[i].mode != model_mode)
                set_mode(quad_cases[i].mode);
            send_quad(quad_cases[i].q, quad_cases[i].typed, quad_cases[i].want);
        end

        // Random phases in alternating modes. The first one opens with the
        // long hold-off; the last one runs flat out on both sides.
        run_random(150, M_BT601,  1'b1, 1'b1);
        run_random(150, M_SHIFT5, 1'b1, 1'b0);
        run_random(100, M_BT601,  1'b1, 1'b0);
        run_random(100, M_SHIFT5, 1'b0, 1'b0);

        @(negedge clk);
        quad_valid = 1'b0;
        while (pending_rgb.size() != 0)
            @(posedge clk);
        repeat (END_SETTLE) @(posedge clk);

        $display("Converted %0d quads (%0d shift-by-5, %0d BT.601), %0d results checked,",
                 quads_sent, quads_shift5, quads_bt601, rgb_checked);
        $display("%0d cycles of input back-pressure, %0d mismatches.",
                 stall_cycles, mismatch_count);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
